@@ rtl/core/chvs_pkg.sv @@
// Package for the chained hash visited set: sizes, codes and memory word layout.
// Used by chvs_ram users, chvs_engine and chained_hash_visited_set.
package chvs_pkg;

	localparam int BUCKETS     = 128;
	localparam int POOL_NODES  = 1024;
	localparam int ALIGN_SHIFT = 5;

	localparam int ADDR_W = 48;
	localparam int WS_W   = 32;
	localparam int BKT_W  = $clog2(BUCKETS);
	localparam int PIDX_W = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
	localparam int LINK_W = $clog2(POOL_NODES + 1);

	localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(POOL_NODES);

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_SEARCH = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	localparam logic [2:0] ST_ADDED   = 3'd0;
	localparam logic [2:0] ST_PRESENT = 3'd1;
	localparam logic [2:0] ST_NULL    = 3'd2;
	localparam logic [2:0] ST_FULL    = 3'd3;
	localparam logic [2:0] ST_CLEARED = 3'd4;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [WS_W-1:0]   ws;
		logic [LINK_W-1:0] link;
	} word_t;

	localparam int WORD_W = $bits(word_t);

	typedef struct packed {
		logic             we;
		logic [BKT_W-1:0] addr;
		word_t            wdata;
	} head_req_t;

	typedef struct packed {
		logic              we;
		logic [PIDX_W-1:0] addr;
		word_t             wdata;
	} pool_req_t;

endpackage

@@ rtl/core/chvs_ram.sv @@
// Generic single-port synchronous RAM, registered read data.
// No dependencies.
module chvs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

@@ rtl/core/chvs_engine.sv @@
// Request sequencer: head lookup, chain walk, insert and clear, result register.
// Depends on chvs_pkg; drives the head and pool RAMs in the top level.
module chvs_engine (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  logic [1:0]                 req_op,
	input  logic [chvs_pkg::ADDR_W-1:0] req_addr,
	input  logic [chvs_pkg::WS_W-1:0]   req_ws,
	output logic                       rsp_valid,
	input  logic                       rsp_ready,
	output logic [2:0]                 rsp_status,
	output logic                       rsp_found,
	output chvs_pkg::head_req_t        head_req,
	input  chvs_pkg::word_t            head_rdata,
	output chvs_pkg::pool_req_t        pool_req,
	input  chvs_pkg::word_t            pool_rdata
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_HEAD = 4'b0010,
		S_POOL = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t state_q, state_d;

	logic [1:0]                  op_q;
	logic [chvs_pkg::ADDR_W-1:0] addr_q;
	logic [chvs_pkg::WS_W-1:0]   ws_q;
	logic [chvs_pkg::BKT_W-1:0]  bkt_q;
	chvs_pkg::word_t             hentry_q;
	logic [chvs_pkg::BUCKETS-1:0] head_valid_q;
	logic [chvs_pkg::LINK_W-1:0] pool_used_q;
	logic [2:0]                  res_status_q;
	logic                        res_found_q;
	logic                        rsp_valid_q;
	logic [2:0]                  rsp_status_q;
	logic                        rsp_found_q;

	logic [chvs_pkg::BKT_W-1:0] req_bkt;
	logic                       hvalid, head_hit, pool_hit, is_insert;
	chvs_pkg::word_t            miss_base;
	logic                       walk_miss;

	assign req_bkt   = req_addr[chvs_pkg::ALIGN_SHIFT +: chvs_pkg::BKT_W];
	assign hvalid    = head_valid_q[bkt_q];
	assign is_insert = (op_q == chvs_pkg::OP_INSERT);
	assign head_hit  = hvalid && head_rdata.addr == addr_q && head_rdata.ws == ws_q;
	assign pool_hit  = pool_rdata.addr == addr_q && pool_rdata.ws == ws_q;
	assign miss_base = (state_q == S_HEAD) ? head_rdata : hentry_q;
	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		state_d        = state_q;
		walk_miss      = 1'b0;
		head_req       = '0;
		pool_req       = '0;
		head_req.addr  = (state_q == S_IDLE) ? req_bkt : bkt_q;
		pool_req.addr  = pool_used_q[chvs_pkg::PIDX_W-1:0];
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = (req_op == chvs_pkg::OP_CLEAR) ? S_DONE : S_HEAD;
				end
			end
			S_HEAD: begin
				state_d = S_DONE;
				if (addr_q == '0 || head_hit) begin
				end else if (!hvalid) begin
					if (is_insert) begin
						head_req.we    = 1'b1;
						head_req.wdata = '{addr: addr_q, ws: ws_q, link: chvs_pkg::NULL_LINK};
					end
				end else if (head_rdata.link < pool_used_q) begin
					pool_req.addr = head_rdata.link[chvs_pkg::PIDX_W-1:0];
					state_d       = S_POOL;
				end else begin
					walk_miss = 1'b1;
				end
			end
			S_POOL: begin
				state_d = S_DONE;
				if (pool_hit) begin
				end else if (pool_rdata.link < pool_used_q) begin
					pool_req.addr = pool_rdata.link[chvs_pkg::PIDX_W-1:0];
					state_d       = S_POOL;
				end else begin
					walk_miss = 1'b1;
				end
			end
			S_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
		if (walk_miss && is_insert && pool_used_q < chvs_pkg::NULL_LINK) begin
			pool_req.we    = 1'b1;
			pool_req.addr  = pool_used_q[chvs_pkg::PIDX_W-1:0];
			pool_req.wdata = '{addr: addr_q, ws: ws_q, link: miss_base.link};
			head_req.we    = 1'b1;
			head_req.wdata = '{addr: miss_base.addr, ws: miss_base.ws, link: pool_used_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			head_valid_q <= '0;
			pool_used_q  <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && req_valid && req_op == chvs_pkg::OP_CLEAR) begin
				head_valid_q <= '0;
				pool_used_q  <= '0;
			end
			if (state_q == S_HEAD && is_insert && addr_q != '0 && !hvalid) begin
				head_valid_q[bkt_q] <= 1'b1;
			end
			if (pool_req.we) begin
				pool_used_q <= pool_used_q + 1'b1;
			end
			if (state_q == S_DONE && (!rsp_valid_q || rsp_ready)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid) begin
			op_q   <= req_op;
			addr_q <= req_addr;
			ws_q   <= req_ws;
			bkt_q  <= req_bkt;
			res_status_q <= chvs_pkg::ST_CLEARED;
			res_found_q  <= 1'b0;
		end
		if (state_q == S_HEAD) begin
			hentry_q <= head_rdata;
		end
		if (state_q == S_HEAD || state_q == S_POOL) begin
			if (state_d == S_DONE) begin
				if (!is_insert) begin
					res_status_q <= chvs_pkg::ST_ADDED;
					res_found_q  <= addr_q != '0 && !walk_miss &&
						((state_q == S_HEAD) ? head_hit : pool_hit);
				end else if (addr_q == '0) begin
					res_status_q <= chvs_pkg::ST_NULL;
				end else if (walk_miss) begin
					res_status_q <= pool_req.we ? chvs_pkg::ST_ADDED : chvs_pkg::ST_FULL;
				end else if (state_q == S_HEAD && !hvalid) begin
					res_status_q <= chvs_pkg::ST_ADDED;
				end else begin
					res_status_q <= chvs_pkg::ST_PRESENT;
				end
			end
		end
		if (state_q == S_DONE && (!rsp_valid_q || rsp_ready)) begin
			rsp_status_q <= res_status_q;
			rsp_found_q  <= res_found_q;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign rsp_status = rsp_status_q;
	assign rsp_found  = rsp_found_q;

	a_pool_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pool_used_q <= chvs_pkg::NULL_LINK)
		else $error("pool count past capacity");

	a_found_search: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_found_q |-> rsp_status_q == chvs_pkg::ST_ADDED)
		else $error("found set with nonzero status");

	a_walk_no_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_POOL |-> op_q != chvs_pkg::OP_CLEAR)
		else $error("chain walk on clear");

	a_direct_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE && $past(state_q == S_IDLE) |-> op_q == chvs_pkg::OP_CLEAR)
		else $error("non-clear request skipped lookup");

endmodule

@@ rtl/core/chained_hash_visited_set.sv @@
// Top level of the chained hash visited set: head RAM, pool RAM and sequencer.
// Depends on chvs_pkg, chvs_ram and chvs_engine.
//
//   channel | signals                                    | dir
//   request | in_valid in_ready opcode object_address walk_state | in
//   result  | out_valid out_ready status found          | out
//
// Per request: a clear skips the lookup; a lookup reads the head, then visits each chain node in turn.
// The chain walk through the pool RAM (one node per cycle) sets how long a lookup takes.
// Reset clears valid bits and the pool count at once; no clearing pass.
// One request in flight; a finished result waits in the output register.
module chained_hash_visited_set (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  opcode,
	input  logic [chvs_pkg::ADDR_W-1:0] object_address,
	input  logic signed [chvs_pkg::WS_W-1:0] walk_state,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [2:0]                  status,
	output logic                        found
);

	chvs_pkg::head_req_t head_req;
	chvs_pkg::pool_req_t pool_req;
	chvs_pkg::word_t     head_rdata, pool_rdata;

	chvs_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (in_valid),
		.req_ready  (in_ready),
		.req_op     (opcode),
		.req_addr   (object_address),
		.req_ws     (walk_state),
		.rsp_valid  (out_valid),
		.rsp_ready  (out_ready),
		.rsp_status (status),
		.rsp_found  (found),
		.head_req   (head_req),
		.head_rdata (head_rdata),
		.pool_req   (pool_req),
		.pool_rdata (pool_rdata)
	);

	chvs_ram #(.WIDTH(chvs_pkg::WORD_W), .DEPTH(chvs_pkg::BUCKETS)) u_head_ram (
		.clk   (clk),
		.we    (head_req.we),
		.addr  (head_req.addr),
		.wdata (head_req.wdata),
		.rdata (head_rdata)
	);

	chvs_ram #(.WIDTH(chvs_pkg::WORD_W), .DEPTH(chvs_pkg::POOL_NODES)) u_pool_ram (
		.clk   (clk),
		.we    (pool_req.we),
		.addr  (pool_req.addr),
		.wdata (pool_req.wdata),
		.rdata (pool_rdata)
	);

endmodule

@@ sim/tb_chained_hash_visited_set.sv @@
// Self-checking testbench for chained_hash_visited_set: insert/search/clear requests
// checked against a behavioral model of the bucket heads and overflow pool.
// Depends on chvs_pkg and the RTL of chained_hash_visited_set.
`timescale 1ns / 1ps

module tb_chained_hash_visited_set;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 600000;
	localparam int CHAIN_LEN = 40;

	typedef struct {
		logic [2:0] status;
		logic       found;
	} reply_t;

	logic                        clk;
	logic                        arst_n;
	logic                        in_valid;
	logic                        in_ready;
	logic [1:0]                  opcode;
	logic [chvs_pkg::ADDR_W-1:0] object_address;
	logic signed [chvs_pkg::WS_W-1:0] walk_state;
	logic                        out_valid;
	logic                        out_ready;
	logic [2:0]                  status;
	logic                        found;

	reply_t      pending_q[$];
	int          fail_cnt = 0;
	int          cycle_cnt = 0;
	bit          idle_en = 1;

	// visited-set model
	bit                          set_head_valid[chvs_pkg::BUCKETS];
	logic [chvs_pkg::ADDR_W-1:0] set_head_addr[chvs_pkg::BUCKETS];
	logic [chvs_pkg::WS_W-1:0]   set_head_ws[chvs_pkg::BUCKETS];
	int                          set_head_link[chvs_pkg::BUCKETS];
	logic [chvs_pkg::ADDR_W-1:0] set_pool_addr[chvs_pkg::POOL_NODES];
	logic [chvs_pkg::WS_W-1:0]   set_pool_ws[chvs_pkg::POOL_NODES];
	int                          set_pool_link[chvs_pkg::POOL_NODES];
	int                          set_pool_used;
	logic [chvs_pkg::ADDR_W-1:0] recent_addr[$];

	chained_hash_visited_set dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .object_address(object_address), .walk_state(walk_state),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .found(found)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	function automatic void empty_set();
		for (int i = 0; i < chvs_pkg::BUCKETS; i++) begin
			set_head_valid[i] = 0;
			set_head_link[i] = chvs_pkg::POOL_NODES;
		end
		set_pool_used = 0;
	endfunction

	function automatic bit pair_visited(int b, logic [chvs_pkg::ADDR_W-1:0] a,
			logic [chvs_pkg::WS_W-1:0] w);
		int link;
		int steps;
		link = set_head_link[b];
		steps = 0;
		if (!set_head_valid[b])
			return 0;
		if (set_head_addr[b] == a && set_head_ws[b] == w)
			return 1;
		while (link < chvs_pkg::POOL_NODES && link < set_pool_used &&
				steps < chvs_pkg::POOL_NODES) begin
			if (set_pool_addr[link] == a && set_pool_ws[link] == w)
				return 1;
			link = set_pool_link[link];
			steps++;
		end
		return 0;
	endfunction

	function automatic reply_t visit_pair(logic [1:0] op, logic [chvs_pkg::ADDR_W-1:0] a,
			logic [chvs_pkg::WS_W-1:0] w);
		reply_t r;
		int b;
		b = int'((a >> chvs_pkg::ALIGN_SHIFT) % chvs_pkg::BUCKETS);
		r.status = chvs_pkg::ST_ADDED;
		r.found = 0;
		if (op == chvs_pkg::OP_CLEAR) begin
			empty_set();
			r.status = chvs_pkg::ST_CLEARED;
		end else if (op == chvs_pkg::OP_INSERT) begin
			if (a == '0)
				r.status = chvs_pkg::ST_NULL;
			else if (!set_head_valid[b]) begin
				set_head_valid[b] = 1;
				set_head_addr[b] = a;
				set_head_ws[b] = w;
				set_head_link[b] = chvs_pkg::POOL_NODES;
			end else if (pair_visited(b, a, w))
				r.status = chvs_pkg::ST_PRESENT;
			else if (set_pool_used >= chvs_pkg::POOL_NODES)
				r.status = chvs_pkg::ST_FULL;
			else begin
				set_pool_addr[set_pool_used] = a;
				set_pool_ws[set_pool_used] = w;
				set_pool_link[set_pool_used] = set_head_link[b];
				set_head_link[b] = set_pool_used;
				set_pool_used++;
			end
		end else
			r.found = (a != '0) && pair_visited(b, a, w);
		return r;
	endfunction

	task automatic send_request(logic [1:0] op, logic [chvs_pkg::ADDR_W-1:0] a,
			logic [chvs_pkg::WS_W-1:0] w);
		if (idle_en && $urandom_range(0, 3) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		in_valid <= 1;
		opcode <= op;
		object_address <= a;
		walk_state <= w;
		do @(posedge clk); while (!in_ready);
		pending_q.push_back(visit_pair(op, a, w));
		if (op == chvs_pkg::OP_INSERT && a != '0 && recent_addr.size() < 64)
			recent_addr.push_back(a);
	endtask

	task automatic drain_results();
		in_valid <= 0;
		while (pending_q.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		reply_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_q.size() == 0) begin
				$error("unexpected result status=%0d found=%0d", status, found);
				fail_cnt++;
			end else begin
				e = pending_q.pop_front();
				if (status !== e.status) begin
					$error("status: expected %0d, actual %0d", e.status, status);
					fail_cnt++;
				end
				if (found !== e.found) begin
					$error("found: expected %0d, actual %0d", e.found, found);
					fail_cnt++;
				end
			end
		end
	end

	initial begin
		out_ready = 1;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (idle_en && $urandom_range(0, 7) == 0) begin
				out_ready <= 0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
				out_ready <= 1;
			end
		end
	end

	task automatic test_directed();
		logic [chvs_pkg::ADDR_W-1:0] amax;
		logic [chvs_pkg::ADDR_W-1:0] alias_a;
		amax = {chvs_pkg::ADDR_W{1'b1}};
		alias_a = 48'h20 + chvs_pkg::ADDR_W'(chvs_pkg::BUCKETS << chvs_pkg::ALIGN_SHIFT);
		send_request(chvs_pkg::OP_INSERT, 48'h0, 32'h1234);
		send_request(chvs_pkg::OP_SEARCH, 48'h0, 32'h1234);
		send_request(chvs_pkg::OP_INSERT, amax, 32'h8000_0000);
		send_request(chvs_pkg::OP_INSERT, amax, 32'h8000_0000);
		send_request(chvs_pkg::OP_INSERT, amax, 32'h7FFF_FFFF);
		send_request(chvs_pkg::OP_SEARCH, amax, 32'h7FFF_FFFF);
		send_request(chvs_pkg::OP_SEARCH, amax, 32'hFFFF_FFFF);
		send_request(chvs_pkg::OP_INSERT, 48'h20, 32'h0);
		send_request(chvs_pkg::OP_INSERT, alias_a, 32'h0);
		send_request(chvs_pkg::OP_INSERT, 48'h21, 32'hFFFF_FFFF);
		send_request(chvs_pkg::OP_SEARCH, 48'h21, 32'hFFFF_FFFF);
		send_request(chvs_pkg::OP_SEARCH, alias_a, 32'h0);
		send_request(OP_UNUSED, 48'h20, 32'h0);
		send_request(OP_UNUSED, 48'h40, 32'h0);
		send_request(chvs_pkg::OP_INSERT, 48'h1F, 32'h5555_AAAA);
		send_request(chvs_pkg::OP_CLEAR, amax, 32'hFFFF_FFFF);
		send_request(chvs_pkg::OP_SEARCH, amax, 32'h7FFF_FFFF);
		send_request(chvs_pkg::OP_SEARCH, 48'h21, 32'hFFFF_FFFF);
		send_request(chvs_pkg::OP_INSERT, 48'h21, 32'hFFFF_FFFF);
		drain_results();
	endtask

	function automatic logic [chvs_pkg::ADDR_W-1:0] chain_addr(int k);
		return chvs_pkg::ADDR_W'((1 + k * chvs_pkg::BUCKETS) << chvs_pkg::ALIGN_SHIFT);
	endfunction

	task automatic test_long_chain();
		for (int k = 0; k < CHAIN_LEN; k++)
			send_request(chvs_pkg::OP_INSERT, chain_addr(k), chvs_pkg::WS_W'(k));
		send_request(chvs_pkg::OP_SEARCH, chain_addr(1), 32'd1);
		send_request(chvs_pkg::OP_SEARCH, chain_addr(1), 32'd2);
		send_request(chvs_pkg::OP_INSERT, chain_addr(20), 32'd20);
		send_request(chvs_pkg::OP_INSERT, chain_addr(20), 32'd21);
		send_request(chvs_pkg::OP_INSERT, 48'h0, 32'h0);
		send_request(chvs_pkg::OP_CLEAR, 48'h0, 32'h0);
		send_request(chvs_pkg::OP_SEARCH, chain_addr(1), 32'd1);
		send_request(chvs_pkg::OP_INSERT, chain_addr(1), 32'd1);
		send_request(chvs_pkg::OP_SEARCH, chain_addr(1), 32'd1);
	endtask

	task automatic test_random(int n);
		logic [1:0]                  op;
		logic [chvs_pkg::ADDR_W-1:0] a;
		logic [chvs_pkg::WS_W-1:0]   w;
		int                          sel;
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(0, 99);
			op = (sel < 45) ? chvs_pkg::OP_INSERT : (sel < 92) ? chvs_pkg::OP_SEARCH :
				(sel < 95) ? OP_UNUSED : chvs_pkg::OP_CLEAR;
			if (op == chvs_pkg::OP_CLEAR)
				recent_addr.delete();
			sel = $urandom_range(0, 99);
			if (sel < 5)
				a = '0;
			else if (sel < 55 && recent_addr.size() != 0)
				a = recent_addr[$urandom_range(0, recent_addr.size() - 1)];
			else if (sel < 80)
				a = chvs_pkg::ADDR_W'($urandom_range(1, 4095));
			else
				a = {16'($urandom), 32'($urandom)};
			w = ($urandom_range(0, 1) == 0) ? chvs_pkg::WS_W'($urandom_range(0, 3)) :
				$urandom;
			send_request(op, a, w);
			if (i == n / 2)
				drain_results();
		end
	endtask

	initial begin
		arst_n = 0;
		in_valid = 0;
		opcode = chvs_pkg::OP_SEARCH;
		object_address = '0;
		walk_state = '0;
		empty_set();
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_long_chain();
		test_random(285);
		idle_en = 0;
		test_random(100);
		drain_results();
		repeat (40) @(posedge clk);
		if (fail_cnt == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

@@ chained_hash_visited_set.f @@
rtl/core/chvs_pkg.sv
rtl/core/chvs_ram.sv
rtl/core/chvs_engine.sv
rtl/core/chained_hash_visited_set.sv
sim/tb_chained_hash_visited_set.sv
